### hw/rtl/tdim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick-driven I2C master package
// Shared types, codes and constants of the tick-driven I2C master.
// ----------------------------------------------------------------------------
package tdim_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_READ_MODE  = CFG_IDX_W'(1);

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_ADDR = 2'd1;
	localparam logic [1:0] ERR_DATA = 2'd2;

	localparam logic [5:0] ADDR_ACK_TICK = 6'd27;
	localparam logic [5:0] DATA_ACK_TICK = 6'd24;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_START = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_ADDR  = 3'd1,
		PH_WRITE = 3'd2,
		PH_READ  = 3'd3,
		PH_STOP  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] load_index;
		logic [7:0] load_byte;
		logic       sda_in;
	} req_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [1:0] err_code;
		logic       rd_valid;
		logic [3:0] rd_index;
		logic [7:0] rd_byte;
	} res_item_t;

	typedef struct packed {
		logic       we;
		logic [4:0] widx;
		logic [7:0] wdata;
		logic [4:0] ridx;
	} buf_req_t;

endpackage

### hw/rtl/tdim_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick-driven I2C master channels
// Valid/ready channels for request items, result items and register writes.
// ----------------------------------------------------------------------------
interface tdim_req_if import tdim_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tdim_res_if import tdim_pkg::*; ();
	logic      valid;
	logic      ready;
	res_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tdim_cfg_if import tdim_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output idx, output data, input ready);
	modport sink(input valid, input idx, input data, output ready);
endinterface

### hw/rtl/tdim_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick-driven I2C master sequencer
// Holds the transfer state and steps it by one request item per transaction.
// ----------------------------------------------------------------------------
module tdim_engine import tdim_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  req_item_t  item,
	input  logic [4:0] byte_count,
	input  logic       read_mode,
	input  logic [7:0] rdata,
	output res_item_t  res,
	output buf_req_t   buf_req
);

	phase_t     phase_q, phase_d;
	logic [5:0] tick_q, tick_d;
	logic [1:0] ph3_q, ph3_d;
	logic [3:0] tdiv_q, tdiv_d;
	logic [4:0] bidx_q, bidx_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic [1:0] err_q, err_d;
	logic [7:0] shift_q, shift_d;

	logic       done;
	logic       rdv;
	logic       is_last;
	logic [2:0] wr_pos;
	logic [2:0] addr_pos;

	assign is_last  = ({1'b0, bidx_q} + 6'd1) >= {1'b0, byte_count};
	assign wr_pos   = ~tdiv_q[2:0];
	assign addr_pos = 3'(4'd8 - tdiv_q);

	always_comb begin
		phase_d       = phase_q;
		tick_d        = tick_q;
		ph3_d         = ph3_q;
		tdiv_d        = tdiv_q;
		bidx_d        = bidx_q;
		scl_d         = scl_q;
		sda_d         = sda_q;
		err_d         = err_q;
		shift_d       = shift_q;
		done          = 1'b0;
		rdv           = 1'b0;
		buf_req.we    = 1'b0;
		buf_req.widx  = bidx_q;
		buf_req.wdata = shift_q;
		case (item.req_type)
			REQ_LOAD: begin
				buf_req.we    = fire;
				buf_req.widx  = {1'b0, item.load_index};
				buf_req.wdata = item.load_byte;
			end
			REQ_START: begin
				if (phase_q == PH_IDLE) begin
					phase_d = PH_ADDR;
					tick_d  = 6'd0;
					ph3_d   = 2'd0;
					tdiv_d  = 4'd0;
					bidx_d  = 5'd0;
					err_d   = ERR_NONE;
					shift_d = 8'd0;
				end
			end
			REQ_TICK: begin
				if (phase_q != PH_IDLE) begin
					tick_d = tick_q + 6'd1;
					if (ph3_q == 2'd2) begin
						ph3_d  = 2'd0;
						tdiv_d = tdiv_q + 4'd1;
					end else begin
						ph3_d = ph3_q + 2'd1;
					end
				end
				case (phase_q)
					PH_ADDR: begin
						if (tick_q == 6'd0) begin
							scl_d = 1'b1;
							sda_d = 1'b1;
						end else if (tick_q == 6'd1) begin
							sda_d = 1'b0;
						end else if (tick_q == 6'd2) begin
							scl_d = 1'b0;
						end else if (tick_q < ADDR_ACK_TICK) begin
							if (ph3_q == 2'd0) begin
								scl_d = 1'b0;
								sda_d = rdata[addr_pos];
							end else begin
								scl_d = (ph3_q == 2'd1);
							end
						end else if (tick_q == ADDR_ACK_TICK) begin
							sda_d = 1'b1;
							scl_d = 1'b1;
						end else if (tick_q == ADDR_ACK_TICK + 6'd1) begin
							if (item.sda_in) begin
								err_d   = ERR_ADDR;
								phase_d = PH_STOP;
								tick_d  = 6'd0;
							end
						end else begin
							scl_d = 1'b0;
							if (is_last) begin
								sda_d   = 1'b0;
								phase_d = PH_STOP;
								tick_d  = 6'd0;
							end else begin
								sda_d   = read_mode;
								phase_d = read_mode ? PH_READ : PH_WRITE;
								bidx_d  = 5'd1;
								tick_d  = 6'd0;
								ph3_d   = 2'd0;
								tdiv_d  = 4'd0;
							end
						end
					end
					PH_WRITE: begin
						if (tick_q < DATA_ACK_TICK) begin
							if (ph3_q == 2'd0) begin
								scl_d = 1'b0;
								sda_d = rdata[wr_pos];
							end else begin
								scl_d = (ph3_q == 2'd1);
							end
						end else if (tick_q == DATA_ACK_TICK) begin
							sda_d = 1'b1;
							scl_d = 1'b1;
						end else if (tick_q == DATA_ACK_TICK + 6'd1) begin
							if (item.sda_in) begin
								err_d   = ERR_DATA;
								phase_d = PH_STOP;
								tick_d  = 6'd0;
							end
						end else if (tick_q == DATA_ACK_TICK + 6'd2) begin
							scl_d = 1'b0;
							sda_d = 1'b0;
						end else begin
							if (is_last) begin
								phase_d = PH_STOP;
								tick_d  = 6'd0;
							end else begin
								bidx_d = bidx_q + 5'd1;
								tick_d = 6'd0;
								ph3_d  = 2'd0;
								tdiv_d = 4'd0;
							end
						end
					end
					PH_READ: begin
						if (tick_q < DATA_ACK_TICK) begin
							if (ph3_q == 2'd0) begin
								scl_d = 1'b1;
							end else if (ph3_q == 2'd1) begin
								shift_d[wr_pos] = item.sda_in;
							end else begin
								scl_d = 1'b0;
							end
						end else if (tick_q == DATA_ACK_TICK) begin
							sda_d      = is_last;
							buf_req.we = fire;
							rdv        = 1'b1;
						end else if (tick_q == DATA_ACK_TICK + 6'd1) begin
							scl_d = 1'b1;
						end else if (tick_q == DATA_ACK_TICK + 6'd2) begin
							scl_d = 1'b0;
						end else begin
							if (is_last) begin
								sda_d   = 1'b0;
								phase_d = PH_STOP;
								tick_d  = 6'd1;
								ph3_d   = 2'd1;
								tdiv_d  = 4'd0;
							end else begin
								sda_d  = 1'b1;
								bidx_d = bidx_q + 5'd1;
								tick_d = 6'd0;
								ph3_d  = 2'd0;
								tdiv_d = 4'd0;
							end
						end
					end
					PH_STOP: begin
						if (tick_q == 6'd0) begin
							scl_d = 1'b0;
							sda_d = 1'b0;
						end else if (tick_q == 6'd1) begin
							scl_d = 1'b1;
						end else begin
							sda_d   = 1'b1;
							done    = 1'b1;
							phase_d = PH_IDLE;
							tick_d  = 6'd0;
							bidx_d  = 5'd0;
						end
					end
					default: begin
						phase_d = PH_IDLE;
						tick_d  = 6'd0;
					end
				endcase
			end
			default: begin
			end
		endcase
		buf_req.ridx = fire ? bidx_d : bidx_q;
	end

	always_comb begin
		res.scl_out  = scl_d;
		res.sda_out  = sda_d;
		res.busy_res = (phase_d != PH_IDLE);
		res.done_res = done;
		res.err_code = err_d;
		res.rd_valid = rdv;
		res.rd_index = rdv ? bidx_q[3:0] : 4'd0;
		res.rd_byte  = rdv ? shift_q : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= 6'd0;
			ph3_q   <= 2'd0;
			tdiv_q  <= 4'd0;
			bidx_q  <= 5'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			err_q   <= ERR_NONE;
			shift_q <= 8'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			ph3_q   <= ph3_d;
			tdiv_q  <= tdiv_d;
			bidx_q  <= bidx_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			err_q   <= err_d;
			shift_q <= shift_d;
		end
	end

endmodule

### hw/rtl/tick_driven_i2c_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick-driven I2C master
// Bit-banged I2C master that moves SCL and SDA one step per tick item.
//
// The req channel carries tick, load and start items; every accepted item
// gives exactly one item on the res channel with the line levels, busy,
// done, error code and any completed read byte. Registers byte_count and
// read_mode are to be written over the cfg channel while no transfer runs;
// the block does not enforce it; cfg is always ready. Each item is handled
// in the cycle it is accepted and, while res keeps up, its result is valid
// in the next cycle, so one item per cycle is sustained. The byte buffer is
// a memory with a registered read port, prefetched from the byte index that
// the step leaves behind and bypassed on a write to the same entry.
// A two-entry output register keeps the req channel ready while one result
// waits; only when both entries are full does req stall until res is taken.
// Reset leaves the lines released high, the master idle, byte_count at one
// and read_mode at zero; buffer contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module tick_driven_i2c_master import tdim_pkg::*; #(
	parameter int BUF_DEPTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	tdim_req_if.sink  req,
	tdim_res_if.source res,
	tdim_cfg_if.sink  cfg
);

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	logic [4:0]    byte_count_q;
	logic          read_mode_q;
	logic [7:0]    mem [BUF_DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] mod_lut [32];
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic          in_fire;
	logic          out_fire;
	res_item_t     step_res;
	buf_req_t      buf_req;
	logic          out_valid_q;
	res_item_t     out_s1;
	logic          skid_valid_q;
	res_item_t     skid_q;

	for (genvar g = 0; g < 32; g++) begin : g_mod
		assign mod_lut[g] = AW'(g % BUF_DEPTH);
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 5'd1;
			read_mode_q  <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.idx)
				CFG_BYTE_COUNT: byte_count_q <= cfg.data[4:0];
				CFG_READ_MODE:  read_mode_q  <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	assign req.ready = !skid_valid_q;
	assign in_fire   = req.valid && req.ready;
	assign out_fire  = out_valid_q && res.ready;

	tdim_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (in_fire),
		.item       (req.data),
		.byte_count (byte_count_q),
		.read_mode  (read_mode_q),
		.rdata      (rdata_q),
		.res        (step_res),
		.buf_req    (buf_req)
	);

	assign waddr = mod_lut[buf_req.widx];
	assign raddr = mod_lut[buf_req.ridx];

	always_ff @(posedge clk) begin
		if (buf_req.we) begin
			mem[waddr] <= buf_req.wdata;
		end
		if (buf_req.we && waddr == raddr) begin
			rdata_q <= buf_req.wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (out_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_s1 <= skid_q;
			end
		end else if (in_fire) begin
			if (out_valid_q && !out_fire) begin
				skid_q <= step_res;
			end else begin
				out_s1 <= step_res;
			end
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_s1;

endmodule

### bench/tick_driven_i2c_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick-driven I2C master testbench
// Drives load, start and tick transactions into the master and checks each
// result transaction against a cycle-free model of the SCL/SDA schedule. It
// covers address-only, write and read transfers, NACK aborts, ignored
// requests and long result back-pressure, then a random phase with varying
// byte counts and read modes.
// ----------------------------------------------------------------------------
module tick_driven_i2c_master_tb import tdim_pkg::*; ();

	localparam int         DEPTH          = 16;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         RANDOM_ITEMS   = 40;
	localparam logic [1:0] REQ_RSVD       = 2'd3;

	logic clk;
	logic arst_n;

	tdim_req_if req_ch();
	tdim_res_if res_ch();
	tdim_cfg_if cfg_ch();

	tick_driven_i2c_master #(.BUF_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	// Model of the master.
	logic [7:0] pr_mem [DEPTH];
	phase_t     pr_phase    = PH_IDLE;
	logic [5:0] pr_tick     = '0;
	logic [4:0] pr_byte_no  = '0;
	logic       pr_scl      = 1'b1;
	logic       pr_sda      = 1'b1;
	logic [1:0] pr_err      = ERR_NONE;
	logic [7:0] pr_shift    = '0;
	logic [4:0] pr_count    = 5'd1;
	logic       pr_rd_mode  = 1'b0;

	res_item_t bus_state_q[$];
	int        mismatches   = 0;
	int        worked_items = 0;
	int        burst_left   = 0;
	bit        no_gaps      = 1'b0;
	int        hold_req     = 0;
	bit        hold_tag     = 1'b0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bit last_byte();
		return int'(pr_byte_no) + 1 >= int'(pr_count);
	endfunction

	function automatic res_item_t step_master(input req_item_t it);
		res_item_t  r;
		logic [5:0] t;
		int         rem;
		int         bit_no;
		logic [7:0] b;
		r = '0;
		case (it.req_type)
			REQ_LOAD: pr_mem[it.load_index] = it.load_byte;
			REQ_START: begin
				if (pr_phase == PH_IDLE) begin
					pr_phase = PH_ADDR;
					pr_tick = '0;
					pr_byte_no = '0;
					pr_err = ERR_NONE;
					pr_shift = '0;
				end
			end
			REQ_TICK: begin
				if (pr_phase != PH_IDLE) begin
					t = pr_tick;
					rem = int'(t) % 3;
					b = pr_mem[int'(pr_byte_no) % DEPTH];
					pr_tick = t + 6'd1;
					case (pr_phase)
						PH_ADDR: begin
							b = pr_mem[0];
							bit_no = 8 - int'(t) / 3;
							if (t == 0) begin
								pr_scl = 1'b1;
								pr_sda = 1'b1;
							end else if (t == 1) begin
								pr_sda = 1'b0;
							end else if (t == 2) begin
								pr_scl = 1'b0;
							end else if (t < ADDR_ACK_TICK) begin
								if (rem == 0) begin
									pr_scl = 1'b0;
									pr_sda = b[bit_no];
								end else begin
									pr_scl = (rem == 1);
								end
							end else if (t == ADDR_ACK_TICK) begin
								pr_sda = 1'b1;
								pr_scl = 1'b1;
							end else if (t == ADDR_ACK_TICK + 1) begin
								if (it.sda_in) begin
									pr_err = ERR_ADDR;
									pr_phase = PH_STOP;
									pr_tick = '0;
								end
							end else begin
								pr_scl = 1'b0;
								if (last_byte()) begin
									pr_sda = 1'b0;
									pr_phase = PH_STOP;
									pr_tick = '0;
								end else begin
									pr_sda = pr_rd_mode;
									pr_phase = pr_rd_mode ? PH_READ : PH_WRITE;
									pr_byte_no = 5'd1;
									pr_tick = '0;
								end
							end
						end
						PH_WRITE: begin
							bit_no = 7 - int'(t) / 3;
							if (t < DATA_ACK_TICK) begin
								if (rem == 0) begin
									pr_scl = 1'b0;
									pr_sda = b[bit_no];
								end else begin
									pr_scl = (rem == 1);
								end
							end else if (t == DATA_ACK_TICK) begin
								pr_sda = 1'b1;
								pr_scl = 1'b1;
							end else if (t == DATA_ACK_TICK + 1) begin
								if (it.sda_in) begin
									pr_err = ERR_DATA;
									pr_phase = PH_STOP;
									pr_tick = '0;
								end
							end else if (t == DATA_ACK_TICK + 2) begin
								pr_scl = 1'b0;
								pr_sda = 1'b0;
							end else if (last_byte()) begin
								pr_phase = PH_STOP;
								pr_tick = '0;
							end else begin
								pr_byte_no = pr_byte_no + 5'd1;
								pr_tick = '0;
							end
						end
						PH_READ: begin
							bit_no = 7 - int'(t) / 3;
							if (t < DATA_ACK_TICK) begin
								if (rem == 0) pr_scl = 1'b1;
								else if (rem == 1) pr_shift[bit_no] = it.sda_in;
								else pr_scl = 1'b0;
							end else if (t == DATA_ACK_TICK) begin
								pr_sda = last_byte();
								pr_mem[int'(pr_byte_no) % DEPTH] = pr_shift;
								r.rd_valid = 1'b1;
								r.rd_index = pr_byte_no[3:0];
								r.rd_byte = pr_shift;
							end else if (t == DATA_ACK_TICK + 1) begin
								pr_scl = 1'b1;
							end else if (t == DATA_ACK_TICK + 2) begin
								pr_scl = 1'b0;
							end else if (last_byte()) begin
								pr_sda = 1'b0;
								pr_phase = PH_STOP;
								pr_tick = 6'd1;
							end else begin
								pr_sda = 1'b1;
								pr_byte_no = pr_byte_no + 5'd1;
								pr_tick = '0;
							end
						end
						PH_STOP: begin
							if (t == 0) begin
								pr_scl = 1'b0;
								pr_sda = 1'b0;
							end else if (t == 1) begin
								pr_scl = 1'b1;
							end else begin
								pr_sda = 1'b1;
								r.done_res = 1'b1;
								pr_phase = PH_IDLE;
								pr_tick = '0;
								pr_byte_no = '0;
							end
						end
						default: begin
							pr_phase = PH_IDLE;
							pr_tick = '0;
						end
					endcase
				end
			end
			default: ;
		endcase
		r.scl_out = pr_scl;
		r.sda_out = pr_sda;
		r.busy_res = (pr_phase != PH_IDLE);
		r.err_code = pr_err;
		return r;
	endfunction

	function automatic req_item_t make_req(input logic [1:0] kind, input logic sda);
		req_item_t it;
		it.req_type = kind;
		it.load_index = 4'($urandom);
		it.load_byte = 8'($urandom);
		it.sda_in = sda;
		return it;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 50) $display("ERROR %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
	endtask

	task automatic send_item(input req_item_t it);
		int gap;
		bit ignored;
		if (burst_left == 0) begin
			gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		ignored = (it.req_type == REQ_RSVD) ||
			(it.req_type == REQ_TICK && pr_phase == PH_IDLE) ||
			(it.req_type == REQ_START && pr_phase != PH_IDLE);
		if (!ignored) worked_items++;
		req_ch.valid = 1'b1;
		req_ch.data = it;
		do @(posedge clk); while (!req_ch.ready);
		bus_state_q.push_back(step_master(it));
		@(negedge clk);
	endtask

	task automatic load_entry(input logic [3:0] idx, input logic [7:0] val);
		req_item_t it;
		it = make_req(REQ_LOAD, 1'($urandom));
		it.load_index = idx;
		it.load_byte = val;
		send_item(it);
	endtask

	task automatic settle();
		req_ch.valid = 1'b0;
		while (bus_state_q.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle();
		cfg_ch.valid = 1'b1;
		cfg_ch.idx = idx;
		cfg_ch.data = val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == CFG_BYTE_COUNT) pr_count = val[4:0];
		else if (idx == CFG_READ_MODE) pr_rd_mode = val[0];
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic configure(input int count, input bit rd_mode);
		write_reg(CFG_BYTE_COUNT, CFG_DATA_W'(count));
		write_reg(CFG_READ_MODE, CFG_DATA_W'(rd_mode));
	endtask

	// A slave NACK is forced on the ACK slot of byte nack_at (0 is the address).
	task automatic run_transfer(input int nack_at, input int nack_pct, input int noise_pct);
		req_item_t it;
		bit        ack_slot;
		send_item(make_req(REQ_START, 1'($urandom)));
		while (pr_phase != PH_IDLE) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				case ($urandom_range(0, 2))
					0: it = make_req(REQ_LOAD, 1'($urandom));
					1: it = make_req(REQ_START, 1'($urandom));
					default: it = make_req(REQ_RSVD, 1'($urandom));
				endcase
			end else begin
				ack_slot = (pr_phase == PH_ADDR && pr_tick == ADDR_ACK_TICK + 1) ||
					(pr_phase == PH_WRITE && pr_tick == DATA_ACK_TICK + 1);
				if (ack_slot)
					it = make_req(REQ_TICK, int'(pr_byte_no) == nack_at ||
						$urandom_range(0, 99) < nack_pct);
				else
					it = make_req(REQ_TICK, 1'($urandom));
			end
			send_item(it);
		end
	endtask

	task automatic test_buffer_load();
		for (int i = 0; i < DEPTH; i++) begin
			load_entry(4'(i), (i == 1) ? 8'hFF : (i == 2) ? 8'h00 : 8'($urandom));
		end
	endtask

	task automatic test_idle_requests();
		send_item(make_req(REQ_TICK, 1'b0));
		send_item(make_req(REQ_TICK, 1'b1));
		send_item(make_req(REQ_RSVD, 1'b1));
	endtask

	task automatic test_address_only();
		configure(0, 1'b1);
		run_transfer(-1, 0, 0);
		configure(1, 1'b0);
		run_transfer(0, 0, 0);
		configure(31, 1'b1);
		run_transfer(0, 0, 0);
	endtask

	task automatic test_write_bytes();
		configure(3, 1'b0);
		run_transfer(-1, 0, 5);
		configure(4, 1'b0);
		run_transfer(2, 0, 0);
	endtask

	task automatic test_read_bytes();
		configure(3, 1'b1);
		run_transfer(-1, 0, 0);
	endtask

	task automatic test_backpressure();
		configure(2, 1'b0);
		no_gaps = 1'b1;
		hold_req = 60;
		hold_tag = !hold_tag;
		run_transfer(-1, 0, 0);
		no_gaps = 1'b0;
		settle();
	endtask

	task automatic test_random();
		int target;
		int n;
		int roll;
		target = worked_items + RANDOM_ITEMS;
		while (worked_items < target) begin
			if ($urandom_range(0, 2) == 0) begin
				roll = $urandom_range(0, 99);
				configure(roll < 75 ? $urandom_range(0, 3) : $urandom_range(4, 8),
					1'($urandom));
			end
			n = $urandom_range(0, 4);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0, 1: load_entry(4'($urandom), 8'($urandom));
					2: send_item(make_req(REQ_TICK, 1'($urandom)));
					default: send_item(make_req(REQ_RSVD, 1'($urandom)));
				endcase
			end
			run_transfer(-1, 8, 6);
		end
	endtask

	// Result side: a stall pattern that is redrawn whenever its age counter wraps, plus a hold-off.
	always @(negedge clk) begin : result_stall
		static logic [15:0] stall_pat = 16'hFFFF;
		static int          pat_age = 0;
		static int          hold_left = 0;
		static bit          seen_tag = 1'b0;
		if (hold_tag != seen_tag) begin
			hold_left = hold_req;
			seen_tag = hold_tag;
		end
		if (pat_age == 0) begin
			if ($urandom_range(0, 3) == 0) stall_pat = 16'hFFFF;
			else stall_pat = 16'($urandom | $urandom) | 16'h0001;
		end
		pat_age = (pat_age + 1) % 64;
		if (hold_left > 0) begin
			res_ch.ready = 1'b0;
			hold_left--;
		end else begin
			res_ch.ready = stall_pat[pat_age % 16];
		end
	end

	always @(posedge clk) begin : result_check
		res_item_t want;
		res_item_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = res_ch.data;
			if (bus_state_q.size() == 0) begin
				report_mismatch("result transaction with nothing expected");
			end else begin
				want = bus_state_q.pop_front();
				compare_field("scl_out", got.scl_out, want.scl_out);
				compare_field("sda_out", got.sda_out, want.sda_out);
				compare_field("busy_res", got.busy_res, want.busy_res);
				compare_field("done_res", got.done_res, want.done_res);
				compare_field("err_code", got.err_code, want.err_code);
				compare_field("rd_valid", got.rd_valid, want.rd_valid);
				compare_field("rd_index", got.rd_index, want.rd_index);
				compare_field("rd_byte", got.rd_byte, want.rd_byte);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		static int quiet = 0;
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < DEPTH; i++) pr_mem[i] = '0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.idx = '0;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_buffer_load();
		test_idle_requests();
		test_address_only();
		test_write_bytes();
		test_read_bytes();
		test_backpressure();
		test_random();

		settle();
		repeat (5) @(posedge clk);
		if (mismatches == 0 && bus_state_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
